@@ design/fpba_pkg.sv @@
// Shared constants, types and helpers for the fit-policy block allocator.
package fpba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W  = (IDX_W > 6) ? IDX_W : 6;
    localparam int SIZE_W = 17;
    localparam int HEAP_W = 21;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } policy_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] req_size;
        logic [5:0]  block_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  granted_index;
        logic        reused;
        logic [16:0] granted_size;
    } rsp_t;

    // Search token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic              active;
        logic              cmd;
        logic [1:0]        policy;
        logic [SIZE_W-1:0] need;
        logic [5:0]        bidx;
        logic [CNT_W-1:0]  count;
        logic              found;
        logic [IDX_W-1:0]  pick_idx;
        logic [SIZE_W-1:0] pick_size;
    } scan_t;

    // Table update broadcast to all cells after a beat completes.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic              free_val;
        logic              set_size;
        logic [SIZE_W-1:0] size;
    } commit_t;

    function automatic logic [5:0] low_gidx(logic [IDX_W-1:0] i);
        logic [CMP_W-1:0] w;
        w = CMP_W'(i);
        return w[5:0];
    endfunction

endpackage

@@ design/fpba_cell.sv @@
// One table entry of the allocator: stored size, free mark and one stage of the search.
module fpba_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fpba_pkg::IDX_W-1:0]    cell_idx,
    input  fpba_pkg::scan_t               scan_in,
    output fpba_pkg::scan_t               scan_out,
    input  fpba_pkg::commit_t             commit
);
    import fpba_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic              free_reg;
    logic              act_reg;
    scan_t             scan_reg;
    scan_t             scan_next;
    logic              in_use;
    logic              fits;
    logic              take;
    logic              hit;

    always_comb
    begin
        in_use = CNT_W'(cell_idx) < scan_in.count;
        fits   = in_use && free_reg && (size_reg >= scan_in.need);
        hit    = in_use && (CMP_W'(cell_idx) == CMP_W'(scan_in.bidx));
        case (scan_in.policy)
            POL_BEST:  take = fits && (!scan_in.found || size_reg < scan_in.pick_size);
            POL_WORST: take = fits && (!scan_in.found || size_reg > scan_in.pick_size);
            default:   take = fits && !scan_in.found;
        endcase

        scan_next = scan_in;
        if (scan_in.cmd == CMD_ALLOC)
        begin
            if (take)
            begin
                scan_next.found     = 1'b1;
                scan_next.pick_idx  = cell_idx;
                scan_next.pick_size = size_reg;
            end
        end
        else if (hit)
        begin
            // found marks a legal free: block in use
            scan_next.found    = !free_reg;
            scan_next.pick_idx = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_reg <= 1'b0;
        else
            act_reg <= scan_in.active;
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    always_ff @(posedge clk)
    begin
        if (commit.we && (commit.idx == cell_idx))
        begin
            free_reg <= commit.free_val;
            if (commit.set_size)
                size_reg <= commit.size;
        end
    end

    always_comb
    begin
        scan_out        = scan_reg;
        scan_out.active = act_reg;
    end

endmodule

@@ design/fit_policy_block_allocator.sv @@
// Top level of the fit-policy block allocator: control, registers and the row of cells.
//
// Usage:
//   A command beat (allocate or free) is taken at a clock edge where start is
//   high and busy is low. Its result appears on rsp for exactly one cycle with
//   done high; the receiver cannot stall it and must take it in that cycle.
//   Every command walks the row of MAX_BLOCKS cells one cell per cycle, and
//   done rises after the search token leaves the last cell. busy stays
//   high from the accepting edge and drops in the done cycle, so the next
//   command may be accepted at the edge that ends it; a new command is not
//   taken while one is still in the row. The table update of a command
//   lands at that same edge, before the next command reaches the first cell.
//   Registers (APB): 0x0 fit_policy, 0x4 heap_capacity; write only while idle.
//   Reset clears the block count, heap usage and control; policy returns to
//   first fit and capacity to 1 MiB. Table entries above the count are never
//   consulted, so they need no clearing.
module fit_policy_block_allocator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  fpba_pkg::req_t  req,
    output logic            done,
    output fpba_pkg::rsp_t  rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import fpba_pkg::*;

    state_t              state_reg, state_next;
    logic [1:0]          policy_reg;
    logic [HEAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [HEAP_W-1:0]   heap_reg, heap_next;
    logic                launch_act_reg;
    scan_t               launch_reg;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;
    commit_t             commit_reg, commit_next;
    scan_t               chain [MAX_BLOCKS+1];
    scan_t               last;
    logic [SIZE_W-1:0]   need;
    logic [HEAP_W:0]     total;
    logic                full;
    logic                room;
    logic                accept;

    // APB configuration
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(cap_reg) : 32'(policy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            cap_reg    <= HEAP_W'(1048576);
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2])
                cap_reg <= pwdata[HEAP_W-1:0];
            else
                policy_reg <= pwdata[1:0];
        end
    end

    // Launch: round the request up to a multiple of 4
    assign accept = start && !busy;
    assign need   = ({1'b0, req.req_size} + SIZE_W'(3)) & ~SIZE_W'(3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            launch_act_reg <= 1'b0;
        else
            launch_act_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            launch_reg.active    <= 1'b1;
            launch_reg.cmd       <= req.cmd;
            launch_reg.policy    <= policy_reg;
            launch_reg.need      <= need;
            launch_reg.bidx      <= req.block_index;
            launch_reg.count     <= count_reg;
            launch_reg.found     <= 1'b0;
            launch_reg.pick_idx  <= '0;
            launch_reg.pick_size <= '0;
        end
    end

    always_comb
    begin
        chain[0]        = launch_reg;
        chain[0].active = launch_act_reg;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            fpba_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDX_W'(g)),
                .scan_in  (chain[g]),
                .scan_out (chain[g+1]),
                .commit   (commit_reg)
            );
        end
    endgenerate

    assign last = chain[MAX_BLOCKS];

    // Finish: decide the outcome once the token leaves the last cell
    assign total = (HEAP_W+1)'(heap_reg) + (HEAP_W+1)'(HEADER_BYTES)
                 + (HEAP_W+1)'(last.need);
    assign full  = count_reg == CNT_W'(MAX_BLOCKS);
    assign room  = total <= {1'b0, cap_reg};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        heap_next   = heap_reg;
        done_next   = 1'b0;
        rsp_next    = '0;
        commit_next = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last.active)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (last.cmd == CMD_FREE)
                    begin
                        rsp_next.status      = last.found ? ST_OK : ST_BADFREE;
                        commit_next.we       = last.found;
                        commit_next.idx      = last.pick_idx;
                        commit_next.free_val = 1'b1;
                    end
                    else if (last.need == '0)
                        rsp_next.status = ST_ZERO;
                    else if (last.found)
                    begin
                        rsp_next.status        = ST_OK;
                        rsp_next.granted_index = low_gidx(last.pick_idx);
                        rsp_next.reused        = 1'b1;
                        rsp_next.granted_size  = last.pick_size;
                        commit_next.we         = 1'b1;
                        commit_next.idx        = last.pick_idx;
                    end
                    else if (full || !room)
                        rsp_next.status = ST_NOSPACE;
                    else
                    begin
                        rsp_next.status        = ST_OK;
                        rsp_next.granted_index = low_gidx(count_reg[IDX_W-1:0]);
                        rsp_next.granted_size  = last.need;
                        commit_next.we         = 1'b1;
                        commit_next.idx        = count_reg[IDX_W-1:0];
                        commit_next.set_size   = 1'b1;
                        commit_next.size       = last.need;
                        count_next             = count_reg + CNT_W'(1);
                        heap_next              = total[HEAP_W-1:0];
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            heap_reg   <= '0;
            done_reg   <= 1'b0;
            commit_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            heap_reg   <= heap_next;
            done_reg   <= done_next;
            commit_reg <= commit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg == S_SCAN);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
